/* rtl/bssc_pkg.sv */
// ----------------------------------------------------------------------------
// bssc_pkg: shared types and constants for button speed step control
// Command codes, configuration layout and result layout.
// ----------------------------------------------------------------------------
package bssc_pkg;

  localparam int DEFAULT_TIME_BITS = 32;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_DATA_BITS     = 16;
  localparam int NUM_BUTTONS       = 3;

  // Step applied by one plus or minus action
  localparam logic signed [9:0] DUTY_STEP = 10'sd5;

  // Register reset values
  localparam logic [6:0]        MAX_FORWARD_RESET = 7'd100;
  localparam logic signed [7:0] MAX_REVERSE_RESET = -8'sd100;
  localparam logic [15:0]       REFRESH_MS_RESET  = 16'd50;

  // Button bit positions
  localparam int BTN_PLUS  = 0;
  localparam int BTN_MINUS = 1;
  localparam int BTN_STOP  = 2;

  typedef enum logic [2:0] {
    CMD_TICK = 3'd0,
    CMD_INC  = 3'd1,
    CMD_DEC  = 3'd2,
    CMD_STOP = 3'd3,
    CMD_HELP = 3'd4
  } cmd_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MAX_FORWARD = 2'd0,
    CFG_MAX_REVERSE = 2'd1,
    CFG_REFRESH_MS  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [6:0]        max_forward;
    logic signed [7:0] max_reverse;
    logic [15:0]       refresh_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [7:0] duty;
    logic              brake_applied;
    logic              help_shown;
  } result_t;

endpackage

/* rtl/bssc_req_if.sv */
// ----------------------------------------------------------------------------
// bssc_req_if: input channel of button speed step control
// One tick or serial command per transaction.
// ----------------------------------------------------------------------------
interface bssc_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic       plus_level;
  logic       minus_level;
  logic       stop_level;

  modport source (output valid, command, plus_level, minus_level, stop_level,
                  input ready);
  modport sink   (input valid, command, plus_level, minus_level, stop_level,
                  output ready);
endinterface

/* rtl/bssc_rsp_if.sv */
// ----------------------------------------------------------------------------
// bssc_rsp_if: result channel of button speed step control
// One duty / brake / help result per transaction.
// ----------------------------------------------------------------------------
interface bssc_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] duty;
  logic              brake_applied;
  logic              help_shown;

  modport source (output valid, duty, brake_applied, help_shown, input ready);
  modport sink   (input valid, duty, brake_applied, help_shown, output ready);
endinterface

/* rtl/bssc_cfg.sv */
// ----------------------------------------------------------------------------
// bssc_cfg: configuration register file
// Clamp limits and lockout interval, write-only.
// ----------------------------------------------------------------------------
module bssc_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bssc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bssc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output bssc_pkg::cfg_t                       cfg
);
  import bssc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_forward <= MAX_FORWARD_RESET;
      cfg.max_reverse <= MAX_REVERSE_RESET;
      cfg.refresh_ms  <= REFRESH_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_FORWARD: cfg.max_forward <= cfg_data[6:0];
        CFG_MAX_REVERSE: cfg.max_reverse <= $signed(cfg_data[7:0]);
        CFG_REFRESH_MS:  cfg.refresh_ms  <= cfg_data[15:0];
        default: ;  // unused index
      endcase
    end
  end

endmodule

/* rtl/bssc_step.sv */
// ----------------------------------------------------------------------------
// bssc_step: next-state and result logic for one transaction
// Lockout gating, held flags, saturating duty steps, command decode.
// ----------------------------------------------------------------------------
module bssc_step #(
  parameter int TIME_BITS = bssc_pkg::DEFAULT_TIME_BITS
) (
  input  bssc_pkg::cfg_t                        cfg,
  input  bssc_pkg::cmd_t                        command,
  input  logic [bssc_pkg::NUM_BUTTONS-1:0]      btn_level,
  input  logic [TIME_BITS-1:0]                  time_ms,
  input  logic [TIME_BITS-1:0]                  lockout_deadline,
  input  logic [bssc_pkg::NUM_BUTTONS-1:0]      held,
  input  logic signed [7:0]                     duty_now,
  output logic [TIME_BITS-1:0]                  time_next,
  output logic [TIME_BITS-1:0]                  deadline_next,
  output logic [bssc_pkg::NUM_BUTTONS-1:0]      held_next,
  output logic signed [7:0]                     duty_next,
  output bssc_pkg::result_t                     result
);
  import bssc_pkg::*;

  function automatic logic signed [7:0] step_up(input logic signed [7:0] d,
                                                input logic [6:0] lim);
    logic signed [9:0] s;
    s = 10'(d) + DUTY_STEP;
    if (s > $signed({3'b000, lim})) begin
      s = $signed({3'b000, lim});
    end
    return s[7:0];
  endfunction

  function automatic logic signed [7:0] step_down(input logic signed [7:0] d,
                                                  input logic signed [7:0] lim);
    logic signed [9:0] s;
    s = 10'(d) - DUTY_STEP;
    if (s < 10'(lim)) begin
      s = 10'(lim);
    end
    return s[7:0];
  endfunction

  logic [TIME_BITS-1:0]   tick_time;
  logic [TIME_BITS-1:0]   refresh_ext;
  logic                   gate;
  logic                   pass_first;
  logic                   pass_again;
  logic                   updated;
  logic                   pass;
  logic [NUM_BUTTONS-1:0] fire;
  logic [NUM_BUTTONS-1:0] held_tick;
  logic signed [7:0]      duty_tick;

  // Button evaluation for a tick. After the first deadline restart in a tick the
  // elapsed value becomes -refresh mod 2^TIME_BITS, independent of the time.
  always_comb begin
    tick_time   = time_ms + TIME_BITS'(1);
    refresh_ext = TIME_BITS'(cfg.refresh_ms);
    gate        = tick_time >= lockout_deadline;
    pass_first  = (tick_time - lockout_deadline) > refresh_ext;
    pass_again  = (TIME_BITS'(0) - refresh_ext) > refresh_ext;
    updated     = 1'b0;
    pass        = 1'b0;
    fire        = '0;
    held_tick   = held;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      pass = updated ? pass_again : pass_first;
      if (gate && pass && ((!btn_level[i]) != held[i])) begin
        held_tick[i] = !held[i];
        fire[i]      = held[i];  // release of an armed button
        updated      = 1'b1;
      end
    end

    duty_tick = duty_now;
    if (fire[BTN_PLUS]) begin
      duty_tick = step_up(duty_tick, cfg.max_forward);
    end
    if (fire[BTN_MINUS]) begin
      duty_tick = step_down(duty_tick, cfg.max_reverse);
    end
    if (fire[BTN_STOP]) begin
      duty_tick = '0;
    end
  end

  always_comb begin
    time_next            = time_ms;
    deadline_next        = lockout_deadline;
    held_next            = held;
    duty_next            = duty_now;
    result.brake_applied = 1'b0;
    result.help_shown    = 1'b0;
    unique case (command)
      CMD_TICK: begin
        time_next            = tick_time;
        deadline_next        = updated ? (tick_time + refresh_ext) : lockout_deadline;
        held_next            = held_tick;
        duty_next            = duty_tick;
        result.brake_applied = fire[BTN_STOP];
      end
      CMD_INC: begin
        duty_next = step_up(duty_now, cfg.max_forward);
      end
      CMD_DEC: begin
        duty_next = step_down(duty_now, cfg.max_reverse);
      end
      CMD_STOP: begin
        duty_next            = '0;
        result.brake_applied = 1'b1;
      end
      default: begin  // help request and undefined codes
        result.help_shown = 1'b1;
      end
    endcase
    result.duty = duty_next;
  end

endmodule

/* rtl/button_speed_step_control.sv */
// ----------------------------------------------------------------------------
// button_speed_step_control: button and serial-command duty controller
// Path: an accepted transaction goes to the input register, then to the result register.
// Throughput: one transaction per cycle while results are taken; with the result
// register held, one more transaction fits in the input register before ready drops.
// Reset (rst, synchronous, active high): time, deadline, held flags and duty
// clear to zero; registers load max_forward 100, max_reverse -100, refresh 50.
// ----------------------------------------------------------------------------
module button_speed_step_control #(
  parameter int TIME_BITS = bssc_pkg::DEFAULT_TIME_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  bssc_req_if.sink                             req,
  bssc_rsp_if.source                           rsp,
  input  logic                                 cfg_we,
  input  logic [bssc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bssc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import bssc_pkg::*;

  // Configuration registers
  cfg_t cfg;

  bssc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register stage
  logic                   s1_valid;
  cmd_t                   s1_cmd;
  logic [NUM_BUTTONS-1:0] s1_level;

  // Controller state
  logic [TIME_BITS-1:0]   time_ms;
  logic [TIME_BITS-1:0]   lockout_deadline;
  logic [NUM_BUTTONS-1:0] held;
  logic signed [7:0]      duty_now;

  // Result register
  logic                   rsp_valid;
  result_t                rsp_data;

  // Next values from the step logic
  logic [TIME_BITS-1:0]   time_next;
  logic [TIME_BITS-1:0]   deadline_next;
  logic [NUM_BUTTONS-1:0] held_next;
  logic signed [7:0]      duty_next;
  result_t                result;

  logic stall;
  logic advance;

  // Result register, state and a full input register hold only when the result register is full and not taken.
  assign stall     = rsp_valid && !rsp.ready;
  assign advance   = s1_valid && !stall;
  assign req.ready = !(s1_valid && stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_cmd   <= cmd_t'(req.command);
      s1_level <= {req.stop_level, req.minus_level, req.plus_level};
    end
  end

  bssc_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .cfg              (cfg),
    .command          (s1_cmd),
    .btn_level        (s1_level),
    .time_ms          (time_ms),
    .lockout_deadline (lockout_deadline),
    .held             (held),
    .duty_now         (duty_now),
    .time_next        (time_next),
    .deadline_next    (deadline_next),
    .held_next        (held_next),
    .duty_next        (duty_next),
    .result           (result)
  );

  // State commits in the same cycle the transaction moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms          <= '0;
      lockout_deadline <= '0;
      held             <= '0;
      duty_now         <= '0;
    end else if (advance) begin
      time_ms          <= time_next;
      lockout_deadline <= deadline_next;
      held             <= held_next;
      duty_now         <= duty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!stall) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= result;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.duty          = rsp_data.duty;
  assign rsp.brake_applied = rsp_data.brake_applied;
  assign rsp.help_shown    = rsp_data.help_shown;

`ifndef ASSERT_OFF
  // A new result only appears after a transaction left the input stage.
  a_rsp_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(s1_valid))
    else $error("result valid without a transaction in the input stage");

  // Time moves by at most one per cycle.
  a_time_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((time_ms - $past(time_ms)) <= TIME_BITS'(1)))
    else $error("time counter jumped");

  // Lockout deadline changes only when a tick is processed.
  a_deadline_tick: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (lockout_deadline != $past(lockout_deadline))
      |-> $past(advance && (s1_cmd == CMD_TICK)))
    else $error("deadline moved outside a tick");

  // A brake result always reports zero duty.
  a_brake_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.brake_applied |-> (rsp_data.duty == 8'sd0))
    else $error("brake with nonzero duty");

  // Help and brake are never reported together.
  a_help_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.help_shown |-> !rsp_data.brake_applied)
    else $error("help and brake in one result");
`endif

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench for button_speed_step_control
// Drives ticks and serial commands through the request channel, predicts the
// duty / brake / help result of every accepted transaction with a local model
// of the controller, and compares each result transaction field by field.
// Runs directed cases first, then random traffic under three handshake
// profiles, a long result stall and a mid-run drain.
// ----------------------------------------------------------------------------
module tb;
  import bssc_pkg::*;

  // Cycles without any accepted transaction before the run is abandoned
  localparam int WATCHDOG_LIMIT = 5000;
  // Settle time waited after the last result is seen
  localparam int SETTLE_CYCLES  = 4;

  // Active-low button level patterns, bit order plus / minus / stop
  localparam logic [2:0] UP_ALL   = 3'b111;
  localparam logic [2:0] DN_PLUS  = 3'b110;
  localparam logic [2:0] DN_MINUS = 3'b101;
  localparam logic [2:0] DN_STOP  = 3'b011;

  logic clk = 1'b0;
  logic rst;

  logic             cfg_we;
  cfg_index_t       cfg_index;
  logic [15:0]      cfg_data;

  bssc_req_if req_ch ();
  bssc_rsp_if rsp_ch ();

  button_speed_step_control u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Handshake profile knobs, written only by the test sequence
  // --------------------------------------------------------------------------
  int tx_idle_pct = 12;
  int rx_idle_pct = 70;
  int stall_len   = 0;
  int stall_seq   = 0;

  // Bookkeeping
  int error_count  = 0;
  int items_sent   = 0;
  int ticks_sent   = 0;
  int cmds_sent    = 0;
  int results_seen = 0;
  int cfg_settings = 0;

  // --------------------------------------------------------------------------
  // Local model of the controller
  // --------------------------------------------------------------------------
  logic [31:0]       ms_count;
  logic [31:0]       lock_deadline;
  logic [2:0]        btn_held;
  logic signed [7:0] duty_model;
  logic [6:0]        fwd_limit;
  logic signed [7:0] rev_limit;
  logic [15:0]       refresh_interval;
  int                plus_fired  = 0;
  int                minus_fired = 0;
  int                stop_fired  = 0;

  result_t duty_due_q[$];

  function automatic logic lockout_clear();
    logic [31:0] since;
    since = ms_count - lock_deadline;   // wraps on purpose
    return since > {16'd0, refresh_interval};
  endfunction

  // Press arms the flag, release fires; both restart the shared deadline
  function automatic logic button_fires(input logic pressed, input int b);
    if (pressed && !btn_held[b] && lockout_clear()) begin
      btn_held[b]   = 1'b1;
      lock_deadline = ms_count + {16'd0, refresh_interval};
    end else if (!pressed && btn_held[b] && lockout_clear()) begin
      btn_held[b]   = 1'b0;
      lock_deadline = ms_count + {16'd0, refresh_interval};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void duty_step_up();
    int d;
    d = int'(duty_model) + int'(DUTY_STEP);
    if (d > int'(fwd_limit)) d = int'(fwd_limit);
    duty_model = d[7:0];
  endfunction

  function automatic void duty_step_down();
    int d;
    d = int'(duty_model) - int'(DUTY_STEP);
    if (d < int'(rev_limit)) d = int'(rev_limit);
    duty_model = d[7:0];
  endfunction

  function automatic result_t predict_duty(input logic [2:0] c, input logic [2:0] lv);
    result_t r;
    logic    brake;
    logic    help;
    brake = 1'b0;
    help  = 1'b0;
    case (c)
      CMD_TICK: begin
        ms_count = ms_count + 32'd1;
        // Gate uses the deadline as it stood at the start of the tick
        if (ms_count >= lock_deadline) begin
          if (button_fires(!lv[BTN_PLUS], BTN_PLUS)) begin
            duty_step_up();
            plus_fired++;
          end
          if (button_fires(!lv[BTN_MINUS], BTN_MINUS)) begin
            duty_step_down();
            minus_fired++;
          end
          if (button_fires(!lv[BTN_STOP], BTN_STOP)) begin
            duty_model = '0;
            brake      = 1'b1;
            stop_fired++;
          end
        end
      end
      CMD_INC:  duty_step_up();
      CMD_DEC:  duty_step_down();
      CMD_STOP: begin
        duty_model = '0;
        brake      = 1'b1;
      end
      default:  help = 1'b1;   // unknown text, codes five to seven too
    endcase
    r.duty          = duty_model;
    r.brake_applied = brake;
    r.help_shown    = help;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: checks result transactions, tracks config, predicts requests.
  // Result is checked before the same-edge request is predicted, so a stray
  // result is never matched against a transaction accepted at that edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    result_t due;
    if (rst) begin
      ms_count         = '0;
      lock_deadline    = '0;
      btn_held         = '0;
      duty_model       = '0;
      fwd_limit        = MAX_FORWARD_RESET;
      rev_limit        = MAX_REVERSE_RESET;
      refresh_interval = REFRESH_MS_RESET;
      duty_due_q.delete();
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (duty_due_q.size() == 0) begin
          $error("result with no pending transaction: duty %0d", rsp_ch.duty);
          error_count++;
        end else begin
          due = duty_due_q.pop_front();
          if (rsp_ch.duty !== due.duty) begin
            $error("duty: expected %0d, got %0d", due.duty, rsp_ch.duty);
            error_count++;
          end
          if (rsp_ch.brake_applied !== due.brake_applied) begin
            $error("brake_applied: expected %0b, got %0b",
                   due.brake_applied, rsp_ch.brake_applied);
            error_count++;
          end
          if (rsp_ch.help_shown !== due.help_shown) begin
            $error("help_shown: expected %0b, got %0b",
                   due.help_shown, rsp_ch.help_shown);
            error_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_FORWARD: fwd_limit        = cfg_data[6:0];
          CFG_MAX_REVERSE: rev_limit        = cfg_data[7:0];
          CFG_REFRESH_MS:  refresh_interval = cfg_data;
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        duty_due_q.push_back(predict_duty(req_ch.command,
                             {req_ch.stop_level, req_ch.minus_level, req_ch.plus_level}));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random ready, plus long stalls on request from the sequence
  // --------------------------------------------------------------------------
  int stall_seen = 0;
  int stall_left = 0;

  always @(posedge clk) begin : result_sink
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_seq != stall_seen) begin
      stall_seen   <= stall_seq;
      stall_left   <= stall_len;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run when nothing moves on either channel for too long
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Shared sequence tasks
  // --------------------------------------------------------------------------

  // Offers one transaction; returns at the edge that accepts it, valid left high
  task automatic send_item(input logic [2:0] c, input logic [2:0] lv);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.command     <= c;
    req_ch.plus_level  <= lv[BTN_PLUS];
    req_ch.minus_level <= lv[BTN_MINUS];
    req_ch.stop_level  <= lv[BTN_STOP];
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    if (c == CMD_TICK) ticks_sent++;
    else cmds_sent++;
  endtask

  // Sender stops and waits for every outstanding result, then lets it settle
  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back, only while the block is idle
  task automatic set_config(input logic [6:0] fwd, input logic signed [7:0] rev,
                            input logic [15:0] refresh);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_FORWARD;
    cfg_data  <= {9'd0, fwd};
    @(posedge clk);
    cfg_index <= CFG_MAX_REVERSE;
    cfg_data  <= {8'd0, rev};
    @(posedge clk);
    cfg_index <= CFG_REFRESH_MS;
    cfg_data  <= refresh;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Right after reset the 50 ms lockout still blocks a press
  task automatic test_reset_lockout();
    send_item(CMD_TICK, DN_PLUS);
    send_item(CMD_TICK, UP_ALL);
  endtask

  // Serial commands act at once; narrow clamps, stray levels, all unknown codes
  task automatic test_serial_commands();
    set_config(7'd7, -8'sd8, 16'd0);
    send_item(CMD_INC,  3'($urandom));
    send_item(CMD_INC,  3'($urandom));   // clamps at max_forward
    send_item(CMD_DEC,  3'($urandom));
    send_item(CMD_DEC,  3'($urandom));
    send_item(CMD_DEC,  3'($urandom));
    send_item(CMD_DEC,  3'($urandom));   // clamps at max_reverse
    send_item(CMD_STOP, 3'($urandom));
    send_item(CMD_HELP, 3'($urandom));
    send_item(3'd5,     3'($urandom));
    send_item(3'd6,     3'($urandom));
    send_item(3'd7,     3'($urandom));
  endtask

  // Press / release edges with zero refresh: a second button in the same tick
  // is held off since the elapsed time equals the interval
  task automatic test_button_edges();
    set_config(7'd100, -8'sd100, 16'd0);
    send_item(CMD_TICK, DN_PLUS);
    send_item(CMD_TICK, UP_ALL);                 // plus fires
    send_item(CMD_TICK, DN_MINUS & DN_STOP);     // minus arms, stop blocked
    send_item(CMD_TICK, DN_MINUS & DN_STOP);     // stop arms
    send_item(CMD_TICK, UP_ALL);                 // minus fires, stop blocked
    send_item(CMD_TICK, UP_ALL);                 // stop fires with brake
  endtask

  // Nonzero refresh: a restarted deadline would land ahead of time and wrap the elapsed-time
  // subtraction, but the press tick still falls inside the lockout, so no button arms
  task automatic test_deadline_wrap();
    set_config(7'd100, -8'sd100, 16'd1);
    send_item(CMD_TICK, DN_PLUS & DN_MINUS);
    send_item(CMD_TICK, UP_ALL);
    send_item(CMD_TICK, UP_ALL);
    send_item(CMD_TICK, UP_ALL);                 // neither button armed, so none fires
  endtask

  // Clamp limits out of order and both at zero
  task automatic test_clamp_extremes();
    set_config(7'd10, 8'sd20, 16'd0);
    send_item(CMD_INC, UP_ALL);
    send_item(CMD_DEC, UP_ALL);                  // pulled up to max_reverse
    set_config(7'd0, 8'sd0, 16'd0);
    send_item(CMD_INC, UP_ALL);                  // pulled down to max_forward
    send_item(CMD_DEC, UP_ALL);
  endtask

  // Widest lockout interval blocks every press
  task automatic test_long_lockout();
    set_config(7'd100, -8'sd100, 16'hFFFF);
    send_item(CMD_TICK, DN_PLUS);
    send_item(CMD_TICK, DN_STOP);
  endtask

  // --------------------------------------------------------------------------
  // Random tests
  // --------------------------------------------------------------------------

  // Buttons mostly held for a few ticks then released, with some noise and
  // serial commands mixed in
  task automatic next_item(inout logic [2:0] lv, output logic [2:0] c);
    if ($urandom_range(99) < 15) c = 3'($urandom_range(7, 1));
    else c = CMD_TICK;
    if ($urandom_range(99) < 8) begin
      lv = 3'($urandom);
    end else begin
      for (int b = 0; b < NUM_BUTTONS; b++)
        if ($urandom_range(4) == 0) lv[b] = ~lv[b];
    end
  endtask

  // Result side stalls for a long stretch while requests keep coming
  task automatic test_backpressure();
    int          saved_tx;
    logic [2:0]  lv;
    logic [2:0]  c;
    set_config(7'd100, -8'sd100, 16'd2);
    saved_tx    = tx_idle_pct;
    tx_idle_pct = 0;
    lv          = UP_ALL;
    stall_len   = 64;
    stall_seq++;
    for (int i = 0; i < 24; i++) begin
      next_item(lv, c);
      send_item(c, lv);
    end
    tx_idle_pct = saved_tx;
  endtask

  task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct,
                                     input logic [6:0] fwd, input logic signed [7:0] rev,
                                     input logic [15:0] refresh);
    logic [2:0] lv;
    logic [2:0] c;
    set_config(fwd, rev, refresh);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    lv          = UP_ALL;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_drain();   // sender pause mid-phase
      next_item(lv, c);
      send_item(c, lv);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int rev_pick;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_MAX_FORWARD;
    cfg_data           <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.command     <= CMD_TICK;
    req_ch.plus_level  <= 1'b1;
    req_ch.minus_level <= 1'b1;
    req_ch.stop_level  <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Profile one: sender idles a little, receiver a lot
    tx_idle_pct = 12;
    rx_idle_pct = 70;
    test_reset_lockout();
    test_serial_commands();
    test_button_edges();
    test_deadline_wrap();
    test_clamp_extremes();
    test_long_lockout();
    test_backpressure();

    rev_pick = $urandom_range(100);
    test_random_traffic(160, 12, 70, 7'($urandom_range(100)), 8'(-rev_pick),
                        16'($urandom_range(3)));
    // Profile two: roles swapped, narrow clamps so limits are hit often
    test_random_traffic(160, 70, 12, 7'd5, -8'sd5, 16'd1);
    // Profile three: full rate, widest clamps, zero refresh
    test_random_traffic(160, 0, 0, 7'd100, -8'sd100, 16'd0);

    wait_drain();
    if (duty_due_q.size() != 0) begin
      $error("%0d expected results never arrived", duty_due_q.size());
      error_count++;
    end

    $display("Covered %0d ticks and %0d serial commands over %0d register settings",
             ticks_sent, cmds_sent, cfg_settings);
    $display("Button actions fired: %0d plus, %0d minus, %0d stop; %0d results checked",
             plus_fired, minus_fired, stop_fired, results_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
